/* hw/rtl/hhss_pkg.sv */
// ----------------------------------------------------------------------------
// hhss_pkg
// Shared types, constants and helpers for the space-saving heavy hitter block.
// ----------------------------------------------------------------------------
`default_nettype none

package hhss_pkg;

  localparam int unsigned NumSlotsDefault = 64;
  localparam int unsigned KeyBitsDefault  = 32;
  localparam int unsigned CntBits         = 32;
  localparam int unsigned OutKeyBits      = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRD,
    ST_SCMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic take_in;
    logic srch;
    logic load_hit;
    logic load_miss;
    logic rd_child;
    logic sift;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic srch_end;
    logic has_child;
    logic swap;
    logic out_free;
  } sts_t;

  function automatic logic [CntBits-1:0] sat_inc(input logic [CntBits-1:0] v);
    sat_inc = (v == {CntBits{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hhss_ctrl.sv */
// ----------------------------------------------------------------------------
// hhss_ctrl
// Sequencer: linear key search, then sift-down one heap level at a time, then output.
// ----------------------------------------------------------------------------
`default_nettype none

module hhss_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hhss_pkg::sts_t sts_i,
  output hhss_pkg::cmd_t     cmd_o
);
  import hhss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SRCH;
      ST_SRCH: if (sts_i.hit || sts_i.srch_end) state_d = ST_SRD;
      ST_SRD:  state_d = sts_i.has_child ? ST_SCMP : ST_DONE;
      ST_SCMP: state_d = sts_i.swap ? ST_SRD : ST_DONE;
      ST_DONE: if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.take_in = in_valid_i;
      end
      ST_SRCH: begin
        cmd_o.srch      = 1'b1;
        cmd_o.load_hit  = sts_i.hit;
        cmd_o.load_miss = !sts_i.hit && sts_i.srch_end;
      end
      ST_SRD:  cmd_o.rd_child = sts_i.has_child;
      ST_SCMP: cmd_o.sift = 1'b1;
      ST_DONE: begin
        cmd_o.fin      = 1'b1;
        cmd_o.out_load = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/hhss_dp.sv */
// ----------------------------------------------------------------------------
// hhss_dp
// Slot memory, valid bits, sift register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hhss_dp #(
  parameter int unsigned NUM_SLOTS = hhss_pkg::NumSlotsDefault,
  parameter int unsigned KEY_BITS  = hhss_pkg::KeyBitsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [hhss_pkg::OutKeyBits-1:0]   item_key_i,
  input  wire hhss_pkg::cmd_t                    cmd_i,
  output hhss_pkg::sts_t                         sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   was_tracked_o,
  output logic [hhss_pkg::CntBits-1:0]           item_count_o,
  output logic [hhss_pkg::CntBits-1:0]           item_error_o,
  output logic                                   evicted_valid_o,
  output logic [hhss_pkg::OutKeyBits-1:0]        evicted_key_o
);
  import hhss_pkg::*;

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = IW + 2;
  localparam int unsigned EW = KEY_BITS + 2 * CntBits;

  logic [EW-1:0]        mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q;
  logic [EW-1:0]        rda_q, rdb_q;
  logic                 rva_q, rvb_q;

  logic [IW-1:0]        ra, rb, wa;
  logic                 we, wv;
  logic [EW-1:0]        wd;

  logic [KEY_BITS-1:0]  key_q;
  logic [IW:0]          scnt_q;
  logic [IW-1:0]        pos_q;
  logic                 rc_ok_q;
  logic [KEY_BITS-1:0]  cur_key_q, root_key_q;
  logic [CntBits-1:0]   cur_cnt_q, cur_err_q, root_cnt_q;
  logic                 cur_vld_q, root_vld_q;
  logic                 trk_q, evv_q;
  logic [OutKeyBits-1:0] evk_q;

  logic [KEY_BITS-1:0]  a_key;
  logic [CntBits-1:0]   a_cnt, a_err, b_cnt;
  logic [EW-1:0]        a_ent, b_ent, p_ent;
  logic [CW-1:0]        lc, rc;
  logic                 pick_r, p_vld, swap;
  logic [CntBits-1:0]   p_cnt;
  logic [IW-1:0]        p_idx;

  assign a_ent = rva_q ? rda_q : '0;
  assign b_ent = rvb_q ? rdb_q : '0;
  assign {a_key, a_cnt, a_err} = a_ent;
  assign b_cnt = b_ent[CntBits +: CntBits];

  assign lc = {1'b0, pos_q, 1'b1};
  assign rc = lc + 1'b1;

  assign pick_r = rc_ok_q && (b_cnt < a_cnt);
  assign p_ent  = pick_r ? b_ent : a_ent;
  assign p_vld  = pick_r ? rvb_q : rva_q;
  assign p_cnt  = p_ent[CntBits +: CntBits];
  assign p_idx  = pick_r ? rc[IW-1:0] : lc[IW-1:0];
  assign swap   = cur_cnt_q > p_cnt;

  assign ra = cmd_i.srch ? scnt_q[IW-1:0] : lc[IW-1:0];
  assign rb = rc[IW-1:0];

  always_comb begin
    we = 1'b0;
    wa = pos_q;
    wd = {cur_key_q, cur_cnt_q, cur_err_q};
    wv = cur_vld_q;
    if (cmd_i.sift && swap) begin
      we = 1'b1;
      wd = p_ent;
      wv = p_vld;
    end else if (cmd_i.fin) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rda_q <= mem_q[ra];
    rdb_q <= mem_q[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rva_q <= 1'b0;
      rvb_q <= 1'b0;
    end else begin
      if (we) vld_q[wa] <= wv;
      rva_q <= vld_q[ra];
      rvb_q <= vld_q[rb];
    end
  end

  assign sts_o.hit       = (scnt_q != '0) && rva_q && (a_key == key_q);
  assign sts_o.srch_end  = (scnt_q == (IW+1)'(NUM_SLOTS));
  assign sts_o.has_child = lc < CW'(NUM_SLOTS);
  assign sts_o.swap      = swap;
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) key_q <= KEY_BITS'(item_key_i);
    if (cmd_i.srch && scnt_q == (IW+1)'(1)) begin
      root_key_q <= a_key;
      root_cnt_q <= a_cnt;
      root_vld_q <= rva_q;
    end
    if (cmd_i.rd_child) rc_ok_q <= rc < CW'(NUM_SLOTS);
    if (cmd_i.load_hit) begin
      cur_key_q <= a_key;
      cur_cnt_q <= sat_inc(a_cnt);
      cur_err_q <= a_err;
      cur_vld_q <= 1'b1;
      pos_q     <= IW'(scnt_q - 1'b1);
      trk_q     <= 1'b1;
      evv_q     <= 1'b0;
      evk_q     <= '0;
    end else if (cmd_i.load_miss) begin
      cur_key_q <= key_q;
      cur_cnt_q <= sat_inc(root_cnt_q);
      cur_err_q <= root_cnt_q;
      cur_vld_q <= 1'b1;
      pos_q     <= '0;
      trk_q     <= 1'b0;
      evv_q     <= root_vld_q;
      evk_q     <= root_vld_q ? OutKeyBits'(root_key_q) : '0;
    end else if (cmd_i.sift && swap) begin
      pos_q <= p_idx;
    end
    if (cmd_i.out_load) begin
      was_tracked_o   <= trk_q;
      item_count_o    <= cur_cnt_q;
      item_error_o    <= cur_err_q;
      evicted_valid_o <= evv_q;
      evicted_key_o   <= evk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.take_in) scnt_q <= '0;
      else if (cmd_i.srch) scnt_q <= scnt_q + 1'b1;
      if (cmd_i.out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/heavy_hitter_space_saving.sv */
// ----------------------------------------------------------------------------
// heavy_hitter_space_saving
// Space-saving frequent item counter over a binary min-heap of slots.
// ----------------------------------------------------------------------------
// channel | signals                         | transaction
// in      | in_valid_i / in_ready_o         | item_key_i
// out     | out_valid_o / out_ready_i       | was_tracked, count, error, eviction
//
// key search scans the slots, one slot a cycle on the memory read port;
// sift-down reads the children of a heap level, then compares and may swap,
// until a leaf or no swap; write back loads the result, and the block returns
// to idle before the next accept.
// reset empties all slots at once through the valid bits.
// the next item is taken while a result waits; a second result stalls write back
`default_nettype none

module heavy_hitter_space_saving #(
  parameter int unsigned NUM_SLOTS = hhss_pkg::NumSlotsDefault,
  parameter int unsigned KEY_BITS  = hhss_pkg::KeyBitsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [hhss_pkg::OutKeyBits-1:0] item_key_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 was_tracked_o,
  output logic [hhss_pkg::CntBits-1:0]         item_count_o,
  output logic [hhss_pkg::CntBits-1:0]         item_error_o,
  output logic                                 evicted_valid_o,
  output logic [hhss_pkg::OutKeyBits-1:0]      evicted_key_o
);
  import hhss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hhss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hhss_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_key_i      (item_key_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .was_tracked_o   (was_tracked_o),
    .item_count_o    (item_count_o),
    .item_error_o    (item_error_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_key_o   (evicted_key_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/hhss_chk.sv */
// ----------------------------------------------------------------------------
// hhss_chk
// Port-level checks for the heavy hitter block.
// ----------------------------------------------------------------------------
`default_nettype none

module hhss_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [31:0] item_key_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        was_tracked_o,
  input wire logic [31:0] item_count_o,
  input wire logic [31:0] item_error_o,
  input wire logic        evicted_valid_o,
  input wire logic [31:0] evicted_key_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(item_count_o)
      && $stable(item_error_o) && $stable(evicted_key_o))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_tracked_o |-> !evicted_valid_o)
    else $error("eviction on hit");

  a_no_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_key_o == 32'd0)
    else $error("evicted key without eviction");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_tracked_o |-> item_count_o == item_error_o + 32'd1
      || (item_count_o == 32'hFFFFFFFF && item_error_o == 32'hFFFFFFFF))
    else $error("insert count not error plus one");

endmodule

bind heavy_hitter_space_saving hhss_chk u_chk (.*);

`default_nettype wire

/* bench/hhss_checker.sv */
// ----------------------------------------------------------------------------
// hhss_checker
// Watches both channels of the heavy hitter block, keeps its own min-heap of
// tracked keys, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module hhss_checker #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [31:0] item_key_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        was_tracked_i,
  input  wire logic [31:0] item_count_i,
  input  wire logic [31:0] item_error_i,
  input  wire logic        evicted_valid_i,
  input  wire logic [31:0] evicted_key_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic        tracked;
    logic [31:0] count;
    logic [31:0] err;
    logic        ev_valid;
    logic [31:0] ev_key;
  } update_t;

  logic [31:0] heap_key [NUM_SLOTS];
  logic [31:0] heap_cnt [NUM_SLOTS];
  logic [31:0] heap_err [NUM_SLOTS];
  logic        heap_vld [NUM_SLOTS];
  update_t     expected_q [$];

  function automatic logic [31:0] cnt_inc(input logic [31:0] v);
    cnt_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic update_t count_key(input logic [31:0] key);
    update_t     u;
    int          hit;
    int          pos;
    int          pick;
    logic [31:0] tk, tc, te;
    logic        tv;
    u = '0;
    hit = -1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (hit < 0 && heap_vld[i] && heap_key[i] == key) hit = i;
    if (hit >= 0) begin
      u.tracked = 1'b1;
      heap_cnt[hit] = cnt_inc(heap_cnt[hit]);
      pos = hit;
    end else begin
      if (heap_vld[0]) begin
        u.ev_valid = 1'b1;
        u.ev_key   = heap_key[0];
      end
      heap_key[0] = key;
      heap_err[0] = heap_cnt[0];
      heap_cnt[0] = cnt_inc(heap_cnt[0]);
      heap_vld[0] = 1'b1;
      pos = 0;
    end
    while (2 * pos + 1 < NUM_SLOTS) begin
      pick = 2 * pos + 1;
      if (pick + 1 < NUM_SLOTS && heap_cnt[pick+1] < heap_cnt[pick]) pick = pick + 1;
      if (heap_cnt[pos] <= heap_cnt[pick]) break;
      tk = heap_key[pos]; tc = heap_cnt[pos]; te = heap_err[pos]; tv = heap_vld[pos];
      heap_key[pos] = heap_key[pick]; heap_cnt[pos] = heap_cnt[pick];
      heap_err[pos] = heap_err[pick]; heap_vld[pos] = heap_vld[pick];
      heap_key[pick] = tk; heap_cnt[pick] = tc; heap_err[pick] = te; heap_vld[pick] = tv;
      pos = pick;
    end
    u.count = heap_cnt[pos];
    u.err   = heap_err[pos];
    return u;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    update_t e;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        heap_key[i] = '0; heap_cnt[i] = '0; heap_err[i] = '0; heap_vld[i] = 1'b0;
      end
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transaction", $time);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== {was_tracked_i, item_count_i, item_error_i, evicted_valid_i,
                     evicted_key_i}) begin
            $display("%0t: mismatch exp trk=%0b cnt=%0h err=%0h ev=%0b key=%0h",
                     $time, e.tracked, e.count, e.err, e.ev_valid, e.ev_key);
            $display("%0t:          act trk=%0b cnt=%0h err=%0h ev=%0b key=%0h",
                     $time, was_tracked_i, item_count_i, item_error_i,
                     evicted_valid_i, evicted_key_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(count_key(item_key_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives key streams into the heavy hitter block: directed keys, hot-key
// skewed random traffic that churns the heap, and random stall phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned Slots    = 64;
  localparam int          CycleMax = 1_500_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] item_key_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        was_tracked_o;
  logic [31:0] item_count_o;
  logic [31:0] item_error_o;
  logic        evicted_valid_o;
  logic [31:0] evicted_key_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_off = 1'b0;
  int          cycle_cnt = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  heavy_hitter_space_saving #(.NUM_SLOTS(Slots), .KEY_BITS(32)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .item_key_i,
    .out_valid_o, .out_ready_i, .was_tracked_o, .item_count_o, .item_error_o,
    .evicted_valid_o, .evicted_key_o
  );

  hhss_checker #(.NUM_SLOTS(Slots)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .item_key_i,
    .out_valid_i(out_valid_o), .out_ready_i, .was_tracked_i(was_tracked_o),
    .item_count_i(item_count_o), .item_error_i(item_error_o),
    .evicted_valid_i(evicted_valid_o), .evicted_key_i(evicted_key_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleMax) begin
      $display("[heavy_hitter_space_saving] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i)
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  task automatic send_key(input logic [31:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    item_key_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // mostly a small hot set so keys get hit and sink; some cold keys evict
  function automatic logic [31:0] pick_key(input int unsigned hot);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 32'h1000 + $urandom_range(hot - 1);
    if (r < 85) return 32'h2000 + $urandom_range(200);
    return $urandom;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    for (int i = 0; i < 8; i++) send_key(32'h8000_0000 >> i);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 27 : 61) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 27 : 61) : 0;
      if (ph == 0) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 160; n++) send_key(pick_key(ph == 2 ? 100 : 40));
      drain();
    end
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("[heavy_hitter_space_saving] OK");
    else $display("[heavy_hitter_space_saving] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
